[rtl/fvr_pkg.sv]
// Package for the face value reduction block: widths, mode codes and word types.
// No dependencies; every other file of the block uses it.
`default_nettype none

package fvr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int EXT_BITS    = SAMPLE_BITS + 1;
  localparam int PROD_BITS   = 2 * EXT_BITS;
  localparam int NUM_BITS    = 48;
  localparam int DEN_BITS    = 34;
  localparam int FRAC_IN     = 8;
  localparam int QUO_BITS    = NUM_BITS + FRAC_IN;
  localparam int REM_BITS    = DEN_BITS + 1;
  localparam int OUT_BITS    = 64;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_SUM          = 3'd0,
    MODE_AREA_AVG     = 3'd1,
    MODE_AREA_INT     = 3'd2,
    MODE_WEIGHTED_AVG = 3'd3,
    MODE_MIN          = 3'd4,
    MODE_MAX          = 3'd5
  } mode_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic        [SAMPLE_BITS-1:0] face_area;
    logic signed [SAMPLE_BITS-1:0] sample_weight;
    logic                          flip;
    logic                          last;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] reduced;
    logic                       zero_divisor;
  } out_word_t;

  // classified face, as queued between front and back
  typedef struct packed {
    mode_e                       mode;
    logic                        last;
    logic signed [PROD_BITS-1:0] term;
    logic signed [EXT_BITS-1:0]  den_term;
    logic signed [EXT_BITS-1:0]  value;
  } q_word_t;

  typedef struct packed {
    logic                start;
    logic                take;
    logic                neg;
    logic [QUO_BITS-1:0] dividend;
    logic [DEN_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic                neg;
    logic [QUO_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/fvr_in_if.sv]
// Input channel of the face value reduction block: valid, ready and one face word.
// Depends on fvr_pkg for the payload type.
`default_nettype none

interface fvr_in_if;
  logic               valid;
  logic               ready;
  fvr_pkg::in_word_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/fvr_out_if.sv]
// Output channel of the face value reduction block: valid, ready and one result word.
// Depends on fvr_pkg for the payload type.
`default_nettype none

interface fvr_out_if;
  logic               valid;
  logic               ready;
  fvr_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/fvr_front.sv]
// Front end: takes face words, applies the flip and forms the product term per mode.
// Depends on fvr_pkg and fvr_in_if; pushes into fvr_queue.
`default_nettype none

module fvr_front (
  fvr_in_if.sink           in_i,
  input  fvr_pkg::mode_e   mode_i,
  input  logic             full_i,
  output logic             push_o,
  output fvr_pkg::q_word_t push_word_o
);
  import fvr_pkg::*;

  logic signed [EXT_BITS-1:0]  v_ext, a_ext, w_ext;
  logic signed [EXT_BITS-1:0]  v_f, a_f, w_f;
  logic signed [EXT_BITS-1:0]  b_op, den_op;
  logic signed [PROD_BITS-1:0] prod;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign v_ext = EXT_BITS'(in_i.payload.sample_value);
  assign a_ext = signed'({1'b0, in_i.payload.face_area});
  assign w_ext = EXT_BITS'(in_i.payload.sample_weight);

  assign v_f = in_i.payload.flip ? -v_ext : v_ext;
  assign a_f = in_i.payload.flip ? -a_ext : a_ext;
  assign w_f = in_i.payload.flip ? -w_ext : w_ext;

  always_comb begin
    b_op   = '0;
    den_op = '0;
    case (mode_i) inside
      MODE_SUM: begin
        b_op = EXT_BITS'(signed'(1 << FRAC_IN));
      end
      MODE_AREA_AVG, MODE_AREA_INT: begin
        b_op   = a_f;
        den_op = a_f;
      end
      MODE_WEIGHTED_AVG: begin
        b_op   = w_f;
        den_op = w_f;
      end
      default: begin
        b_op   = '0;
        den_op = '0;
      end
    endcase
  end

  assign prod = v_f * b_op;

  assign push_word_o.mode     = mode_i;
  assign push_word_o.last     = in_i.payload.last;
  assign push_word_o.term     = prod;
  assign push_word_o.den_term = den_op;
  assign push_word_o.value    = v_f;

endmodule

`default_nettype wire

[rtl/fvr_queue.sv]
// Short register queue between front and back ends.
// Depends on fvr_pkg for the queued word and its depth.
`default_nettype none

module fvr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fvr_pkg::q_word_t push_word_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output fvr_pkg::q_word_t pop_word_o
);
  import fvr_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  q_word_t               mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o     = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_word_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

`default_nettype wire

[rtl/fvr_divider.sv]
// Restoring divider, one quotient bit per cycle, unsigned magnitudes plus a sign.
// Depends on fvr_pkg for widths and request/response structs.
`default_nettype none

module fvr_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fvr_pkg::div_req_t req_i,
  output fvr_pkg::div_rsp_t rsp_o
);
  import fvr_pkg::*;

  localparam int CNT_BITS = $clog2(QUO_BITS);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

  div_state_e            state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [REM_BITS-1:0]   rem_q, rem_d;
  logic [QUO_BITS-1:0]   quo_q, quo_d;
  logic [DEN_BITS-1:0]   dvs_q, dvs_d;
  logic                  neg_q, neg_d;
  logic [REM_BITS-1:0]   rem_sh;
  logic [REM_BITS:0]     diff;
  logic                  ge;

  assign rem_sh = {rem_q[REM_BITS-2:0], quo_q[QUO_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[REM_BITS];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          rem_d   = '0;
          quo_d   = req_i.dividend;
          dvs_d   = req_i.divisor;
          neg_d   = req_i.neg;
          cnt_d   = CNT_BITS'(QUO_BITS - 1);
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_d = ge ? diff[REM_BITS-1:0] : rem_sh;
        quo_d = {quo_q[QUO_BITS-2:0], ge};
        if (cnt_q == '0) begin
          state_d = DIV_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      DIV_DONE: begin
        if (req_i.take) begin
          state_d = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy     = (state_q != DIV_IDLE);
  assign rsp_o.done     = (state_q == DIV_DONE);
  assign rsp_o.neg      = neg_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

[rtl/fvr_back.sv]
// Back end: accumulates queued faces, forms the result on the last face of a set.
// Depends on fvr_pkg, fvr_out_if and fvr_divider; pops from fvr_queue.
`default_nettype none

module fvr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  fvr_pkg::q_word_t word_i,
  output logic             pop_o,
  fvr_out_if.source        out_o
);
  import fvr_pkg::*;

  logic signed [NUM_BITS-1:0] num_q, num_d, num_next;
  logic signed [DEN_BITS-1:0] den_q, den_d, den_next;
  logic signed [EXT_BITS-1:0] ext_q, ext_d, ext_next;
  logic                       first_q, first_d;
  logic                       out_valid_q, out_valid_d;
  out_word_t                  out_word_q, out_word_d;

  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  logic                       out_free, need_div, direct_load, div_take, take_ext;
  logic [NUM_BITS-1:0]        num_mag;
  logic [DEN_BITS-1:0]        den_mag;
  logic [OUT_BITS-1:0]        quo_ext;
  out_word_t                  direct_word;

  assign out_free = !out_valid_q || out_o.ready;

  // a last face waits until the divider is free and the output can take it
  assign pop_o = valid_i && (!word_i.last || (!div_rsp.busy && out_free));

  always_comb begin
    num_next = num_q;
    den_next = den_q;
    ext_next = ext_q;
    take_ext = 1'b0;
    case (word_i.mode) inside
      MODE_SUM: begin
        num_next = num_q + NUM_BITS'(word_i.term);
      end
      MODE_AREA_AVG, MODE_AREA_INT, MODE_WEIGHTED_AVG: begin
        num_next = num_q + NUM_BITS'(word_i.term);
        den_next = den_q + DEN_BITS'(word_i.den_term);
      end
      MODE_MIN: begin
        take_ext = !first_q || (word_i.value < ext_q);
      end
      MODE_MAX: begin
        take_ext = !first_q || (word_i.value > ext_q);
      end
      default: begin
        take_ext = 1'b0;
      end
    endcase
    if (take_ext) begin
      ext_next = word_i.value;
    end
  end

  always_comb begin
    direct_word = '0;
    need_div    = 1'b0;
    case (word_i.mode) inside
      MODE_SUM, MODE_AREA_INT: begin
        direct_word.reduced = OUT_BITS'(num_next);
      end
      MODE_AREA_AVG, MODE_WEIGHTED_AVG: begin
        if (den_next == '0) begin
          direct_word.zero_divisor = 1'b1;
        end else begin
          need_div = 1'b1;
        end
      end
      MODE_MIN, MODE_MAX: begin
        direct_word.reduced = OUT_BITS'(ext_next) <<< FRAC_IN;
      end
      default: begin
        direct_word = '0;
      end
    endcase
  end

  assign num_mag = num_next[NUM_BITS-1] ? NUM_BITS'(-num_next) : NUM_BITS'(num_next);
  assign den_mag = den_next[DEN_BITS-1] ? DEN_BITS'(-den_next) : DEN_BITS'(den_next);

  assign direct_load = pop_o && word_i.last && !need_div;
  assign div_take    = div_rsp.done && out_free;

  assign div_req.start    = pop_o && word_i.last && need_div;
  assign div_req.take     = div_take;
  assign div_req.neg      = num_next[NUM_BITS-1] ^ den_next[DEN_BITS-1];
  assign div_req.dividend = {num_mag, FRAC_IN'(0)};
  assign div_req.divisor  = den_mag;

  fvr_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign quo_ext = OUT_BITS'(div_rsp.quotient);

  always_comb begin
    num_d       = num_q;
    den_d       = den_q;
    ext_d       = ext_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_word_d  = out_word_q;
    if (pop_o) begin
      if (word_i.last) begin
        num_d   = '0;
        den_d   = '0;
        ext_d   = '0;
        first_d = 1'b0;
      end else begin
        num_d   = num_next;
        den_d   = den_next;
        ext_d   = ext_next;
        first_d = 1'b1;
      end
    end
    if (direct_load) begin
      out_valid_d = 1'b1;
      out_word_d  = direct_word;
    end else if (div_take) begin
      out_valid_d                = 1'b1;
      out_word_d.reduced         = div_rsp.neg ? signed'(-quo_ext) : signed'(quo_ext);
      out_word_d.zero_divisor    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q       <= '0;
      den_q       <= '0;
      ext_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      num_q       <= num_d;
      den_q       <= den_d;
      ext_q       <= ext_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

endmodule

`default_nettype wire

[rtl/face_value_reduction_top.sv]
// Face value reduction: faces into a 4-deep queue, one per cycle unless it is full; one word a set.
// Throughput: one face per cycle, set by the single back-end accumulate stage; last faces may wait.
// A sum, integral, min or max result is registered at the edge that takes its last face.
// An average with a nonzero divisor runs the bit-serial divider, and the next last face
// waits for it. Reset clears mode (sum), accumulators, queue and output; no clearing pass.
// Depends on fvr_pkg, fvr_in_if, fvr_out_if, fvr_front, fvr_queue, fvr_back.
`default_nettype none

module face_value_reduction_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  fvr_in_if.sink      in_i,
  fvr_out_if.source   out_o
);
  import fvr_pkg::*;

  mode_e   mode_q, mode_d;
  logic    q_push, q_full, q_pop, q_valid;
  q_word_t q_push_word, q_pop_word;

  assign mode_d = cfg_we_i ? mode_e'(cfg_wdata_i) : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SUM;
    end else begin
      mode_q <= mode_d;
    end
  end

  fvr_front u_front (
    .in_i        (in_i),
    .mode_i      (mode_q),
    .full_i      (q_full),
    .push_o      (q_push),
    .push_word_o (q_push_word)
  );

  fvr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (q_push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (q_pop_word)
  );

  fvr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .word_i  (q_pop_word),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
